>>> rtl/core/assert_macros.svh
// Assertion macros used by the top level of the arbiter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TMA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TMA_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define TMA_ASSERT(lbl, prop, msg)
`define TMA_NEVER(lbl, cond, msg)
`endif
`endif

>>> rtl/core/tma_pkg.sv
// Package with the types and constants of the TDMA memory phase arbiter.
package tma_pkg;

	localparam int unsigned COUNTER_BITS_DEF = 64;

	localparam logic [31:0] SLOT_PERIOD_RST = 32'd62500000;
	localparam logic [4:0]  NUM_SLOTS_RST   = 5'd3;
	localparam logic [3:0]  OWN_SLOT_RST    = 4'd0;

	localparam logic [1:0] REG_SLOT_PERIOD = 2'd0;
	localparam logic [1:0] REG_NUM_SLOTS   = 2'd1;
	localparam logic [1:0] REG_OWN_SLOT    = 2'd2;

	localparam logic [1:0] FUNC_BEGIN   = 2'd0;
	localparam logic [1:0] FUNC_END     = 2'd1;
	localparam logic [1:0] FUNC_UNKNOWN = 2'd2;
	localparam logic [1:0] FUNC_TICK    = 2'd3;

	localparam logic [1:0] RSP_NONE    = 2'd0;
	localparam logic [1:0] RSP_ACK     = 2'd1;
	localparam logic [1:0] RSP_NACK    = 2'd2;
	localparam logic [1:0] RSP_INVALID = 2'd3;

	localparam logic [1:0] PH_COMPUTING = 2'd0;
	localparam logic [1:0] PH_MEMORY    = 2'd1;
	localparam logic [1:0] PH_WAITING   = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_DIV,
		S_MUL,
		S_ADD,
		S_OUT
	} tma_state_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic div_step;
		logic mul;
		logic add;
	} tma_cmd_t;

	typedef struct packed {
		logic arm_req;
		logic div_last;
	} tma_status_t;

endpackage

>>> rtl/core/tma_ctrl.sv
// Controller state machine that sequences one transaction through the datapath.
module tma_ctrl import tma_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  tma_status_t status,
	output tma_cmd_t    cmd
);

	tma_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_nx = S_EVAL;
			end
			S_EVAL: begin
				state_nx = status.arm_req ? S_DIV : S_OUT;
			end
			S_DIV: begin
				if (status.div_last) state_nx = S_MUL;
			end
			S_MUL: state_nx = S_ADD;
			S_ADD: state_nx = S_OUT;
			S_OUT: begin
				if (out_ready) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_EVAL: cmd.eval = 1'b1;
			S_DIV:  cmd.div_step = 1'b1;
			S_MUL:  cmd.mul = 1'b1;
			S_ADD:  cmd.add = 1'b1;
			S_OUT:  out_valid = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

>>> rtl/core/tma_datapath.sv
// Datapath with configuration, phase state, bit-serial slot division and compare arithmetic.
module tma_datapath import tma_pkg::*; #(
	parameter int unsigned COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [1:0]  func,
	input  logic [63:0] now,
	input  tma_cmd_t    cmd,
	output tma_status_t status,
	output logic [1:0]  response,
	output logic        phase_end_signal,
	output logic [1:0]  phase_now,
	output logic        timer_armed,
	output logic [63:0] compare_value
);

	localparam int unsigned CntW = $clog2(COUNTER_BITS);

	logic [31:0] slot_period_q;
	logic [4:0]  num_slots_q;
	logic [3:0]  own_slot_q;

	logic [1:0]              phase_q;
	logic                    tie_q;
	logic                    armed_q;
	logic [COUNTER_BITS-1:0] cmp_q;
	logic [1:0]              rsp_q;
	logic                    pend_q;

	logic [1:0]              func_q;
	logic [COUNTER_BITS-1:0] now_q;
	logic [COUNTER_BITS-1:0] nsh_q;
	logic [31:0]             rem_q;
	logic [4:0]              mod_q;
	logic [CntW-1:0]         cnt_q;
	logic [37:0]             dp_q;
	logic [COUNTER_BITS-1:0] base_q;

	logic       ok;
	logic [1:0] rsp_e;
	logic       pend_e;
	logic [1:0] phase_e;
	logic       armed_e;
	logic       arm_req;

	logic [32:0] trial;
	logic        qbit;
	logic [31:0] rem_nx;
	logic [5:0]  mod_sh;
	logic [4:0]  mod_nx;
	logic        in_slot;
	logic [5:0]  slot_dist;

	assign ok = (slot_period_q != 32'd0) && (num_slots_q != 5'd0)
		&& ({1'b0, own_slot_q} < num_slots_q);

	always_comb begin
		rsp_e = RSP_NONE;
		pend_e = 1'b0;
		phase_e = phase_q;
		armed_e = armed_q;
		arm_req = 1'b0;
		if (func_q == FUNC_TICK) begin
			if (armed_q && (now_q >= cmp_q)) begin
				armed_e = 1'b0;
				if (ok) begin
					if (!tie_q) begin
						if (phase_q == PH_WAITING) begin
							arm_req = 1'b1;
							phase_e = PH_MEMORY;
						end
					end else if (phase_q == PH_MEMORY) begin
						pend_e = 1'b1;
						arm_req = 1'b1;
						phase_e = PH_WAITING;
					end
				end
			end
		end else if (!ok || func_q == FUNC_UNKNOWN) begin
			rsp_e = RSP_INVALID;
		end else if (func_q == FUNC_BEGIN) begin
			if (phase_q == PH_COMPUTING) begin
				arm_req = 1'b1;
			end else begin
				rsp_e = RSP_INVALID;
			end
		end else begin
			if (phase_q == PH_COMPUTING) begin
				rsp_e = RSP_INVALID;
			end else begin
				armed_e = 1'b0;
				phase_e = PH_COMPUTING;
				rsp_e = RSP_ACK;
			end
		end
	end

	assign trial  = {rem_q, nsh_q[COUNTER_BITS-1]};
	assign qbit   = (trial >= {1'b0, slot_period_q});
	assign rem_nx = qbit ? 32'(trial - {1'b0, slot_period_q}) : trial[31:0];
	assign mod_sh = {mod_q, qbit};
	assign mod_nx = (mod_sh >= {1'b0, num_slots_q}) ? 5'(mod_sh - {1'b0, num_slots_q})
		: mod_sh[4:0];

	assign in_slot = (mod_q == {1'b0, own_slot_q});
	assign slot_dist = in_slot ? 6'd1
		: (mod_q < {1'b0, own_slot_q}) ? 6'({2'b0, own_slot_q} - {1'b0, mod_q})
		: 6'({2'b0, own_slot_q} + {1'b0, num_slots_q} - {1'b0, mod_q});

	assign status.arm_req  = arm_req;
	assign status.div_last = (cnt_q == CntW'(COUNTER_BITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_period_q <= SLOT_PERIOD_RST;
			num_slots_q <= NUM_SLOTS_RST;
			own_slot_q <= OWN_SLOT_RST;
			phase_q <= PH_COMPUTING;
			tie_q <= 1'b0;
			armed_q <= 1'b0;
			cmp_q <= '1;
			rsp_q <= RSP_NONE;
			pend_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SLOT_PERIOD: slot_period_q <= cfg_data;
					REG_NUM_SLOTS:   num_slots_q <= cfg_data[4:0];
					REG_OWN_SLOT:    own_slot_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (cmd.eval) begin
				rsp_q <= rsp_e;
				pend_q <= pend_e;
				phase_q <= phase_e;
				armed_q <= armed_e;
			end
			if (cmd.add) begin
				cmp_q <= COUNTER_BITS'(base_q + COUNTER_BITS'(dp_q));
				armed_q <= 1'b1;
				tie_q <= in_slot;
				if (func_q == FUNC_BEGIN) begin
					phase_q <= in_slot ? PH_MEMORY : PH_WAITING;
					rsp_q <= in_slot ? RSP_ACK : RSP_NACK;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			now_q <= now[COUNTER_BITS-1:0];
			nsh_q <= now[COUNTER_BITS-1:0];
		end
		if (cmd.eval) begin
			rem_q <= '0;
			mod_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_nx;
			mod_q <= mod_nx;
			nsh_q <= nsh_q << 1;
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.mul) begin
			dp_q <= 38'(slot_dist) * 38'(slot_period_q);
			base_q <= now_q - COUNTER_BITS'(rem_q);
		end
	end

	assign response = rsp_q;
	assign phase_end_signal = pend_q;
	assign phase_now = phase_q;
	assign timer_armed = armed_q;
	assign compare_value = 64'(cmp_q);

endmodule

>>> rtl/core/tdma_memory_phase_arbiter.sv
// Top level of the TDMA memory phase arbiter.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    func, now
// out      output     out_valid / out_ready  response, phase_end_signal, phase_now,
//                                            timer_armed, compare_value
// cfg      input      cfg_we                 cfg_index, cfg_data
//
// A transaction that arms the comparator runs a restoring division by the slot period,
// one quotient bit a cycle, then a multiply and an add; any other goes from evaluation
// straight to the result. One transaction is in the block at a time.
// Reset restores the register defaults and leaves the core computing with the timer idle.
// A result waits in place while out_ready is low; no new transaction is taken meanwhile.
`include "assert_macros.svh"
module tdma_memory_phase_arbiter import tma_pkg::*; #(
	parameter int unsigned COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [63:0] now,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  response,
	output logic        phase_end_signal,
	output logic [1:0]  phase_now,
	output logic        timer_armed,
	output logic [63:0] compare_value
);

	tma_cmd_t    cmd;
	tma_status_t status;

	tma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	tma_datapath #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.func             (func),
		.now              (now),
		.cmd              (cmd),
		.status           (status),
		.response         (response),
		.phase_end_signal (phase_end_signal),
		.phase_now        (phase_now),
		.timer_armed      (timer_armed),
		.compare_value    (compare_value)
	);

	`TMA_NEVER(a_one_in_flight, in_ready && out_valid, "Input taken while a result is pending.")
	`TMA_ASSERT(a_ready_after_out, out_valid && out_ready |=> in_ready, "Not ready after result.")
	`TMA_ASSERT(a_phase_end_rearms, out_valid && phase_end_signal |-> phase_now == PH_WAITING && timer_armed, "Phase end without re-arming.")
	`TMA_ASSERT(a_nack_waits, out_valid && response == RSP_NACK |-> phase_now == PH_WAITING && timer_armed, "Nack without waiting state.")

endmodule
